// ===== rtl/erc_pkg.sv =====
// Package with the shared widths, constants and sequencer states of the extent read chunk mapper.
`timescale 1ns / 1ps

package erc_pkg;

    localparam int EXTENT_SLOTS   = 8;
    localparam int SLOT_W         = $clog2(EXTENT_SLOTS);
    localparam int BLOCK_BYTES    = 4096;
    localparam int BOFF_W         = $clog2(BLOCK_BYTES);
    localparam int CHUNK_W        = BOFF_W + 1;
    localparam int MAX_READ_BYTES = 131072;
    localparam int LEN_W          = 18;
    localparam int PB_W           = 48;
    localparam int SUM_W          = PB_W + 1;
    localparam int EXT_LEN_W      = 32;
    localparam int SIZE_W         = 47;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EXTENT_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLIP,
        S_END,
        S_TEST,
        S_LOCAL,
        S_BASE,
        S_EMIT,
        S_EMPTY
    } state_t;

endpackage

// ===== rtl/extent_read_chunk_mapper.sv =====
// Top level of the extent read chunk mapper: extent table, sequencer and shared 49-bit adder.
`timescale 1ns / 1ps
// An extent load item is written into the table when accepted. A read item checks and clips
// its range in S_CHECK and S_CLIP, then takes S_END for each extent of zero length, S_END and
// S_TEST for each extent skipped, S_END, S_TEST, S_LOCAL and S_BASE to enter the extent that
// holds the data and S_EMIT per chunk, using the shared 49-bit adder. Chunks stall when the
// output register is still full. Reset clears the extent table and sets vol_reg to 1.

module extent_read_chunk_mapper (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [erc_pkg::PB_W-1:0]        cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [erc_pkg::SLOT_W-1:0]      s_extent_slot,
    input  logic [erc_pkg::PB_W-1:0]        s_extent_first_block,
    input  logic [erc_pkg::EXT_LEN_W-1:0]   s_extent_blocks,
    input  logic [erc_pkg::SIZE_W-1:0]      s_file_size,
    input  logic [erc_pkg::SIZE_W-1:0]      s_read_offset,
    input  logic [erc_pkg::LEN_W-1:0]       s_read_length,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [erc_pkg::PB_W-1:0]        m_fetch_block,
    output logic [erc_pkg::BOFF_W-1:0]      m_start_byte,
    output logic [erc_pkg::CHUNK_W-1:0]     m_chunk_bytes,
    output logic                            m_whole_block,
    output logic [erc_pkg::LEN_W-1:0]       m_dest_offset,
    output logic                            m_status,
    output logic                            m_last
);

    erc_pkg::state_t state_reg, state_next;

    logic [erc_pkg::PB_W-1:0]      vol_reg;
    logic [erc_pkg::PB_W-1:0]      ext_first_reg [erc_pkg::EXTENT_SLOTS];
    logic [erc_pkg::EXT_LEN_W-1:0] ext_len_reg [erc_pkg::EXTENT_SLOTS];

    logic [erc_pkg::SIZE_W-1:0]    fsize_reg, fsize_next;
    logic [erc_pkg::PB_W-1:0]      pos_reg, pos_next;
    logic [erc_pkg::PB_W-1:0]      diff_reg, diff_next;
    logic [erc_pkg::LEN_W-1:0]     remaining_reg, remaining_next;
    logic [erc_pkg::LEN_W-1:0]     delivered_reg, delivered_next;
    logic [erc_pkg::PB_W-1:0]      ext_start_reg, ext_start_next;
    logic [erc_pkg::PB_W-1:0]      ext_end_reg, ext_end_next;
    logic [erc_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [erc_pkg::BOFF_W-1:0]    boff_reg, boff_next;
    logic [erc_pkg::SUM_W-1:0]     pb_reg, pb_next;
    logic [erc_pkg::EXT_LEN_W-1:0] idx_reg, idx_next;
    logic [erc_pkg::EXT_LEN_W-1:0] blk_left_reg, blk_left_next;

    logic                          m_valid_reg, m_valid_next;
    logic [erc_pkg::PB_W-1:0]      out_pb_reg, out_pb_next;
    logic [erc_pkg::BOFF_W-1:0]    out_boff_reg, out_boff_next;
    logic [erc_pkg::CHUNK_W-1:0]   out_bytes_reg, out_bytes_next;
    logic                          out_whole_reg, out_whole_next;
    logic [erc_pkg::LEN_W-1:0]     out_dest_reg, out_dest_next;
    logic                          out_status_reg, out_status_next;
    logic                          out_last_reg, out_last_next;

    logic [erc_pkg::PB_W-1:0]      alu_a, alu_b;
    logic                          alu_cin;
    logic [erc_pkg::SUM_W-1:0]     alu_sum;
    logic                          alu_carry;

    logic [erc_pkg::PB_W-1:0]      cur_first;
    logic [erc_pkg::EXT_LEN_W-1:0] cur_len;
    logic [erc_pkg::EXTENT_SLOTS-1:0] nz_vec;
    logic [erc_pkg::SLOT_W:0]      later_shamt;
    logic                          later_nz;
    logic [erc_pkg::LEN_W-1:0]     len_sat;
    logic [erc_pkg::CHUNK_W-1:0]   room;
    logic [erc_pkg::CHUNK_W-1:0]   chunk;
    logic [erc_pkg::LEN_W-1:0]     rem_after;
    logic                          ext_done;
    logic                          chunk_last;
    logic                          blk_err;
    logic                          out_free;
    logic                          accept;
    logic                          slot_is_last;

    assign s_ready          = (state_reg == erc_pkg::S_IDLE);
    assign accept           = s_valid && s_ready;
    assign out_free         = !m_valid_reg || m_ready;
    assign cur_first        = ext_first_reg[slot_reg];
    assign cur_len          = ext_len_reg[slot_reg];
    assign slot_is_last     = (slot_reg == erc_pkg::LAST_SLOT);

    assign len_sat = (s_read_length > erc_pkg::LEN_W'(erc_pkg::MAX_READ_BYTES)) ?
                     erc_pkg::LEN_W'(erc_pkg::MAX_READ_BYTES) : s_read_length;

    always_comb begin
        for (int k = 0; k < erc_pkg::EXTENT_SLOTS; k++) begin
            nz_vec[k] = |ext_len_reg[k];
        end
    end

    assign later_shamt = {1'b0, slot_reg} + (erc_pkg::SLOT_W + 1)'(1);
    assign later_nz    = |(nz_vec >> later_shamt);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (state_reg)
            erc_pkg::S_CHECK: begin
                alu_a   = {1'b0, fsize_reg};
                alu_b   = ~pos_reg;
                alu_cin = 1'b1;
            end
            erc_pkg::S_END: begin
                alu_a = ext_start_reg;
                alu_b = erc_pkg::PB_W'({cur_len, erc_pkg::BOFF_W'(0)});
            end
            erc_pkg::S_TEST: begin
                alu_a   = pos_reg;
                alu_b   = ~ext_end_reg;
                alu_cin = 1'b1;
            end
            erc_pkg::S_LOCAL: begin
                alu_a   = pos_reg;
                alu_b   = ~ext_start_reg;
                alu_cin = 1'b1;
            end
            erc_pkg::S_BASE: begin
                alu_a = cur_first;
                alu_b = erc_pkg::PB_W'(idx_reg);
            end
            erc_pkg::S_EMIT: begin
                alu_a   = pb_reg[erc_pkg::PB_W-1:0];
                alu_b   = ~vol_reg;
                alu_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b} + erc_pkg::SUM_W'(alu_cin);
    assign alu_carry = alu_sum[erc_pkg::PB_W];

    assign blk_err    = pb_reg[erc_pkg::PB_W] || alu_carry;
    assign room       = erc_pkg::CHUNK_W'(erc_pkg::BLOCK_BYTES) - {1'b0, boff_reg};
    assign chunk      = (remaining_reg < erc_pkg::LEN_W'(room)) ?
                        remaining_reg[erc_pkg::CHUNK_W-1:0] : room;
    assign rem_after  = remaining_reg - erc_pkg::LEN_W'(chunk);
    assign ext_done   = (blk_left_reg == erc_pkg::EXT_LEN_W'(1));
    assign chunk_last = (rem_after == '0) || (ext_done && !later_nz);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            erc_pkg::S_IDLE: begin
                if (accept && s_mode) begin
                    state_next = erc_pkg::S_CHECK;
                end
            end
            erc_pkg::S_CHECK: begin
                if (remaining_reg == '0 || !alu_carry || alu_sum[erc_pkg::PB_W-1:0] == '0) begin
                    state_next = erc_pkg::S_EMPTY;
                end else begin
                    state_next = erc_pkg::S_CLIP;
                end
            end
            erc_pkg::S_CLIP: begin
                state_next = erc_pkg::S_END;
            end
            erc_pkg::S_END: begin
                if (cur_len == '0) begin
                    state_next = slot_is_last ? erc_pkg::S_EMPTY : erc_pkg::S_END;
                end else begin
                    state_next = erc_pkg::S_TEST;
                end
            end
            erc_pkg::S_TEST: begin
                if (alu_carry) begin
                    state_next = slot_is_last ? erc_pkg::S_EMPTY : erc_pkg::S_END;
                end else begin
                    state_next = erc_pkg::S_LOCAL;
                end
            end
            erc_pkg::S_LOCAL: begin
                state_next = erc_pkg::S_BASE;
            end
            erc_pkg::S_BASE: begin
                state_next = erc_pkg::S_EMIT;
            end
            erc_pkg::S_EMIT: begin
                if (out_free) begin
                    if (blk_err || chunk_last) begin
                        state_next = erc_pkg::S_IDLE;
                    end else if (ext_done) begin
                        state_next = erc_pkg::S_END;
                    end
                end
            end
            erc_pkg::S_EMPTY: begin
                if (out_free) begin
                    state_next = erc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = erc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        fsize_next      = fsize_reg;
        pos_next        = pos_reg;
        diff_next       = diff_reg;
        remaining_next  = remaining_reg;
        delivered_next  = delivered_reg;
        ext_start_next  = ext_start_reg;
        ext_end_next    = ext_end_reg;
        slot_next       = slot_reg;
        boff_next       = boff_reg;
        pb_next         = pb_reg;
        idx_next        = idx_reg;
        blk_left_next   = blk_left_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_pb_next     = out_pb_reg;
        out_boff_next   = out_boff_reg;
        out_bytes_next  = out_bytes_reg;
        out_whole_next  = out_whole_reg;
        out_dest_next   = out_dest_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            erc_pkg::S_IDLE: begin
                if (accept && s_mode) begin
                    fsize_next     = s_file_size;
                    pos_next       = {1'b0, s_read_offset};
                    remaining_next = len_sat;
                    delivered_next = '0;
                    ext_start_next = '0;
                    slot_next      = '0;
                end
            end
            erc_pkg::S_CHECK: begin
                diff_next = alu_sum[erc_pkg::PB_W-1:0];
            end
            erc_pkg::S_CLIP: begin
                if (diff_reg < erc_pkg::PB_W'(remaining_reg)) begin
                    remaining_next = diff_reg[erc_pkg::LEN_W-1:0];
                end
            end
            erc_pkg::S_END: begin
                if (cur_len == '0) begin
                    slot_next = slot_reg + erc_pkg::SLOT_W'(1);
                end else begin
                    ext_end_next = alu_sum[erc_pkg::PB_W-1:0];
                end
            end
            erc_pkg::S_TEST: begin
                if (alu_carry) begin
                    ext_start_next = ext_end_reg;
                    slot_next      = slot_reg + erc_pkg::SLOT_W'(1);
                end
            end
            erc_pkg::S_LOCAL: begin
                boff_next = alu_sum[erc_pkg::BOFF_W-1:0];
                idx_next  = alu_sum[erc_pkg::BOFF_W +: erc_pkg::EXT_LEN_W];
            end
            erc_pkg::S_BASE: begin
                pb_next       = alu_sum;
                blk_left_next = cur_len - idx_reg;
            end
            erc_pkg::S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_pb_next   = pb_reg[erc_pkg::PB_W-1:0];
                    out_boff_next = boff_reg;
                    out_dest_next = delivered_reg;
                    out_last_next = 1'b1;
                    if (blk_err) begin
                        out_bytes_next  = '0;
                        out_whole_next  = 1'b0;
                        out_status_next = 1'b1;
                    end else begin
                        out_bytes_next  = chunk;
                        out_whole_next  = (boff_reg == '0) &&
                                          (chunk == erc_pkg::CHUNK_W'(erc_pkg::BLOCK_BYTES));
                        out_status_next = 1'b0;
                        out_last_next   = chunk_last;
                        remaining_next  = rem_after;
                        delivered_next  = delivered_reg + erc_pkg::LEN_W'(chunk);
                        boff_next       = '0;
                        pb_next         = pb_reg + erc_pkg::SUM_W'(1);
                        blk_left_next   = blk_left_reg - erc_pkg::EXT_LEN_W'(1);
                        if (ext_done) begin
                            ext_start_next = ext_end_reg;
                            pos_next       = ext_end_reg;
                            slot_next      = slot_reg + erc_pkg::SLOT_W'(1);
                        end
                    end
                end
            end
            erc_pkg::S_EMPTY: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_pb_next     = '0;
                    out_boff_next   = '0;
                    out_bytes_next  = '0;
                    out_whole_next  = 1'b0;
                    out_dest_next   = '0;
                    out_status_next = 1'b0;
                    out_last_next   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= erc_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            vol_reg     <= erc_pkg::PB_W'(1);
            for (int k = 0; k < erc_pkg::EXTENT_SLOTS; k++) begin
                ext_first_reg[k] <= '0;
                ext_len_reg[k]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                vol_reg <= cfg_wr_data;
            end
            if (accept && !s_mode) begin
                ext_first_reg[s_extent_slot] <= s_extent_first_block;
                ext_len_reg[s_extent_slot]   <= s_extent_blocks;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fsize_reg      <= fsize_next;
        pos_reg        <= pos_next;
        diff_reg       <= diff_next;
        remaining_reg  <= remaining_next;
        delivered_reg  <= delivered_next;
        ext_start_reg  <= ext_start_next;
        ext_end_reg    <= ext_end_next;
        slot_reg       <= slot_next;
        boff_reg       <= boff_next;
        pb_reg         <= pb_next;
        idx_reg        <= idx_next;
        blk_left_reg   <= blk_left_next;
        out_pb_reg     <= out_pb_next;
        out_boff_reg   <= out_boff_next;
        out_bytes_reg  <= out_bytes_next;
        out_whole_reg  <= out_whole_next;
        out_dest_reg   <= out_dest_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_fetch_block    = out_pb_reg;
    assign m_start_byte     = out_boff_reg;
    assign m_chunk_bytes    = out_bytes_reg;
    assign m_whole_block    = out_whole_reg;
    assign m_dest_offset    = out_dest_reg;
    assign m_status         = out_status_reg;
    assign m_last           = out_last_reg;

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_last && m_chunk_bytes == '0)
        else $error("Error item is not the final item of its read.");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chunk_bytes == '0 |-> m_last)
        else $error("Item without bytes is not the final item.");

    a_whole_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_whole_block |->
            m_start_byte == '0 && !m_status &&
            m_chunk_bytes == erc_pkg::CHUNK_W'(erc_pkg::BLOCK_BYTES))
        else $error("Whole-block flag set on a partial chunk.");

    a_emit_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == erc_pkg::S_EMIT |-> remaining_reg != '0 && blk_left_reg != '0)
        else $error("Chunk emission entered with nothing left to map.");

endmodule
